>>> hw/rtl/abba_pkg.sv
// abba_pkg: widths, constants, types and helpers shared by the site pattern accumulator
// no dependencies; compiled first
`timescale 1ns / 1ps

package abba_pkg;

    localparam int TRIO_W            = 10;
    localparam int FREQ_W            = 17;
    localparam int MASK_W            = 4;
    localparam int SUM_W             = 56;
    localparam int CNT_W             = 32;
    localparam int PAIR_W            = 33;
    localparam int TERM_W            = 33;
    localparam int MAX_TRIOS         = 2 ** TRIO_W;
    localparam int NUM_TRIOS_DEFAULT = 1024;

    localparam logic [FREQ_W-1:0] ONE_Q16 = FREQ_W'(65536);
    localparam logic [SUM_W-1:0]  SUM_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    // one trio's accumulators as held in a single memory word
    typedef struct packed {
        logic [SUM_W-1:0] abba;
        logic [SUM_W-1:0] baba;
        logic [SUM_W-1:0] bbaa;
        logic [CNT_W-1:0] used_first;
        logic [CNT_W-1:0] used_second;
        logic [CNT_W-1:0] used_third;
    } entry_t;

    // four-factor products of one site, Q.32
    typedef struct packed {
        logic [TERM_W-1:0] abba;
        logic [TERM_W-1:0] baba;
        logic [TERM_W-1:0] bbaa;
        logic [TERM_W-1:0] baab;
        logic [TERM_W-1:0] abab;
        logic [TERM_W-1:0] aabb;
    } terms_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } state_t;

    function automatic logic [FREQ_W-1:0] clamp_freq(input logic [FREQ_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

>>> hw/rtl/abba_ifs.sv
// abba_ifs: valid/ready channels for site words and result words
// depends on abba_pkg
`timescale 1ns / 1ps

interface abba_site_if;
    import abba_pkg::*;

    logic              valid;
    logic              ready;
    logic [TRIO_W-1:0] trio_index;
    logic [FREQ_W-1:0] freq_first;
    logic [FREQ_W-1:0] freq_second;
    logic [FREQ_W-1:0] freq_third;
    logic [FREQ_W-1:0] freq_outgroup;
    logic [MASK_W-1:0] missing_mask;

    modport source (
        output valid, trio_index, freq_first, freq_second, freq_third,
               freq_outgroup, missing_mask,
        input  ready
    );

    modport sink (
        input  valid, trio_index, freq_first, freq_second, freq_third,
               freq_outgroup, missing_mask,
        output ready
    );
endinterface

interface abba_result_if;
    import abba_pkg::*;

    logic             valid;
    logic             ready;
    logic             skipped;
    logic [SUM_W-1:0] abba_sum;
    logic [SUM_W-1:0] baba_sum;
    logic [SUM_W-1:0] bbaa_sum;
    logic [CNT_W-1:0] used_first_pair;
    logic [CNT_W-1:0] used_second_pair;
    logic [CNT_W-1:0] used_third_pair;

    modport source (
        output valid, skipped, abba_sum, baba_sum, bbaa_sum,
               used_first_pair, used_second_pair, used_third_pair,
        input  ready
    );

    modport sink (
        input  valid, skipped, abba_sum, baba_sum, bbaa_sum,
               used_first_pair, used_second_pair, used_third_pair,
        output ready
    );
endinterface

>>> hw/rtl/abba_terms.sv
// abba_terms: two-stage multiplier array forming the six four-factor site products
// depends on abba_pkg
`timescale 1ns / 1ps

module abba_terms (
    input  logic                         clk,
    input  logic                         load_pair,
    input  logic                         load_term,
    input  logic [abba_pkg::FREQ_W-1:0]  p1,
    input  logic [abba_pkg::FREQ_W-1:0]  p2,
    input  logic [abba_pkg::FREQ_W-1:0]  p3,
    input  logic [abba_pkg::FREQ_W-1:0]  po,
    output abba_pkg::terms_t             terms
);
    import abba_pkg::*;

    localparam int PROD_W = 2 * PAIR_W;

    logic [FREQ_W-1:0] q1, q2, q3, qo;

    logic [PAIR_W-1:0] q1p2_reg, p3qo_reg, p1q2_reg, p1p2_reg;
    logic [PAIR_W-1:0] q3qo_reg, q3po_reg, q1q2_reg, p3po_reg;
    terms_t            terms_reg;

    // product of two UQ1.16 values, at most 2^32
    function automatic logic [PAIR_W-1:0] mul_pair(
        input logic [FREQ_W-1:0] a,
        input logic [FREQ_W-1:0] b
    );
        logic [2*FREQ_W-1:0] p;
        p = (2*FREQ_W)'(a) * (2*FREQ_W)'(b);
        return p[PAIR_W-1:0];
    endfunction

    // floor(x*y / 2^32), at most 2^32
    function automatic logic [TERM_W-1:0] mul_q32(
        input logic [PAIR_W-1:0] x,
        input logic [PAIR_W-1:0] y
    );
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(y);
        return p[32 +: TERM_W];
    endfunction

    assign q1 = ONE_Q16 - p1;
    assign q2 = ONE_Q16 - p2;
    assign q3 = ONE_Q16 - p3;
    assign qo = ONE_Q16 - po;

    always_ff @(posedge clk)
    begin
        if (load_pair)
        begin
            q1p2_reg <= mul_pair(q1, p2);
            p3qo_reg <= mul_pair(p3, qo);
            p1q2_reg <= mul_pair(p1, q2);
            p1p2_reg <= mul_pair(p1, p2);
            q3qo_reg <= mul_pair(q3, qo);
            q3po_reg <= mul_pair(q3, po);
            q1q2_reg <= mul_pair(q1, q2);
            p3po_reg <= mul_pair(p3, po);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_term)
        begin
            terms_reg.abba <= mul_q32(q1p2_reg, p3qo_reg);
            terms_reg.baba <= mul_q32(p1q2_reg, p3qo_reg);
            terms_reg.bbaa <= mul_q32(p1p2_reg, q3qo_reg);
            terms_reg.baab <= mul_q32(p1q2_reg, q3po_reg);
            terms_reg.abab <= mul_q32(q1p2_reg, q3po_reg);
            terms_reg.aabb <= mul_q32(q1q2_reg, p3po_reg);
        end
    end

    assign terms = terms_reg;

endmodule

>>> hw/rtl/abba_baba_site_pattern_accumulator_core.sv
// abba_baba_site_pattern_accumulator_core: per-trio ABBA/BABA/BBAA totals and pair counts
// depends on abba_pkg, abba_ifs and abba_terms
`timescale 1ns / 1ps

// Takes one site word at a time, and no new one until the last has left the add stage:
// accepting a word reads the trio's entry from the accumulator memory, the product stage
// forms the 33x33 products, and the add stage adds, writes back and loads the result word.
// A result waiting on the output holds the next one in the add stage until it is taken.
// After reset the block sweeps the memory to zero, one entry a cycle, and takes no site
// words until all min(NUM_TRIOS, 1024) entries are clear; patterson_mode may be
// written at any time while no site is in flight.
module abba_baba_site_pattern_accumulator_core #(
    parameter int NUM_TRIOS = abba_pkg::NUM_TRIOS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    abba_site_if.sink     site,
    abba_result_if.source result,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);
    import abba_pkg::*;

    localparam int DEPTH  = (NUM_TRIOS < MAX_TRIOS) ? NUM_TRIOS : MAX_TRIOS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic              pmode_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              range_ok_reg;
    logic              skip_reg;
    logic              extra_reg;
    entry_t            rd_reg;
    logic              res_valid_reg;
    logic              res_skipped_reg;
    entry_t            res_entry_reg;

    entry_t            mem [DEPTH];

    logic [FREQ_W-1:0] p1, p2, p3, po;
    logic              accept;
    logic              site_ready;
    logic              load_out;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    entry_t            mem_wd;
    logic              range_ok;
    logic              skip;
    terms_t            terms;
    entry_t            upd;
    entry_t            out_entry;
    logic              nz_abba, nz_baba, nz_bbaa;

    function automatic logic [SUM_W-1:0] sat_sum(
        input logic [SUM_W-1:0]  acc,
        input logic [TERM_W-1:0] a,
        input logic [TERM_W-1:0] b
    );
        logic [SUM_W+1:0] s;
        s = (SUM_W+2)'(acc) + (SUM_W+2)'(a) + (SUM_W+2)'(b);
        return (s > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(
        input logic [CNT_W-1:0] c,
        input logic             en
    );
        return (en && c != CNT_MAX) ? c + CNT_W'(1) : c;
    endfunction

    // site word decode
    assign p1     = clamp_freq(site.freq_first);
    assign p2     = clamp_freq(site.freq_second);
    assign p3     = clamp_freq(site.freq_third);
    assign po     = clamp_freq(site.freq_outgroup);
    assign accept = site.valid && site_ready;

    assign range_ok = 32'(site.trio_index) < 32'(NUM_TRIOS);
    assign skip     = (site.missing_mask != '0)
                   || (p1 == '0 && p2 == '0 && p3 == '0)
                   || (p1 == ONE_Q16 && p2 == ONE_Q16 && p3 == ONE_Q16);

    abba_terms u_terms (
        .clk       (clk),
        .load_pair (accept),
        .load_term (state_reg == ST_MUL),
        .p1        (p1),
        .p2        (p2),
        .p3        (p3),
        .po        (po),
        .terms     (terms)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            pmode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg     <= site.trio_index[ADDR_W-1:0];
            range_ok_reg <= range_ok;
            skip_reg     <= skip;
            extra_reg    <= pmode_reg && (po != '0);
        end
    end

    // accumulator memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= mem[site.trio_index[ADDR_W-1:0]];
        end
    end

    // update of the read entry; patterson terms fold into the same saturating add
    assign nz_abba = terms.abba != '0;
    assign nz_baba = terms.baba != '0;
    assign nz_bbaa = terms.bbaa != '0;

    always_comb
    begin
        upd.abba        = sat_sum(rd_reg.abba, terms.abba, extra_reg ? terms.baab : '0);
        upd.baba        = sat_sum(rd_reg.baba, terms.baba, extra_reg ? terms.abab : '0);
        upd.bbaa        = sat_sum(rd_reg.bbaa, terms.bbaa, extra_reg ? terms.aabb : '0);
        upd.used_first  = cnt_inc(rd_reg.used_first, nz_abba || nz_baba);
        upd.used_second = cnt_inc(rd_reg.used_second, nz_abba || nz_bbaa);
        upd.used_third  = cnt_inc(rd_reg.used_third, nz_bbaa || nz_baba);

        if (!range_ok_reg)
        begin
            out_entry = '0;
        end
        else if (skip_reg)
        begin
            out_entry = rd_reg;
        end
        else
        begin
            out_entry = upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        site_ready = 1'b0;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = addr_reg;
        mem_wd     = upd;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = '0;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                site_ready = 1'b1;
                if (site.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    mem_we     = range_ok_reg && !skip_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_skipped_reg <= skip_reg || !range_ok_reg;
            res_entry_reg   <= out_entry;
        end
    end

    assign site.ready              = site_ready;
    assign result.valid            = res_valid_reg;
    assign result.skipped          = res_skipped_reg;
    assign result.abba_sum         = res_entry_reg.abba;
    assign result.baba_sum         = res_entry_reg.baba;
    assign result.bbaa_sum         = res_entry_reg.bbaa;
    assign result.used_first_pair  = res_entry_reg.used_first;
    assign result.used_second_pair = res_entry_reg.used_second;
    assign result.used_third_pair  = res_entry_reg.used_third;

    // an accepted word walks the product stage and then the add stage
    a_word_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MUL ##1 state_reg == ST_ADD)
        else $error("accepted site word did not follow the product and add stages");

    // only one word in flight: no new word while the previous one is in the pipe
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !site.ready ##1 !site.ready)
        else $error("site word accepted while another was in flight");

    // a result word only appears out of the add stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_ADD))
        else $error("result word raised outside the add stage");

endmodule
